@@ rtl/core/rsm_pkg.sv @@
// shared constants and functions for the row softmax block
package rsm_pkg;

    localparam int RowMaxDefault = 64;
    localparam int SampleWidth   = 16;
    localparam int ProbWidth     = 16;
    localparam int LenWidth      = 7;
    localparam int SumWidth      = 23;
    localparam int RecipWidth    = 38;
    localparam logic [16:0] Log2eQ16 = 17'd94548;

    function automatic logic [15:0] pow2_frac(input logic [4:0] idx);
        logic [15:0] r;
        begin
            case (idx)
                5'd0:  r = 16'd32768;
                5'd1:  r = 16'd32066;
                5'd2:  r = 16'd31379;
                5'd3:  r = 16'd30706;
                5'd4:  r = 16'd30048;
                5'd5:  r = 16'd29405;
                5'd6:  r = 16'd28774;
                5'd7:  r = 16'd28158;
                5'd8:  r = 16'd27554;
                5'd9:  r = 16'd26964;
                5'd10: r = 16'd26386;
                5'd11: r = 16'd25821;
                5'd12: r = 16'd25268;
                5'd13: r = 16'd24726;
                5'd14: r = 16'd24196;
                5'd15: r = 16'd23678;
                5'd16: r = 16'd23170;
                5'd17: r = 16'd22674;
                5'd18: r = 16'd22188;
                5'd19: r = 16'd21713;
                5'd20: r = 16'd21247;
                5'd21: r = 16'd20792;
                5'd22: r = 16'd20347;
                5'd23: r = 16'd19911;
                5'd24: r = 16'd19484;
                5'd25: r = 16'd19066;
                5'd26: r = 16'd18658;
                5'd27: r = 16'd18258;
                5'd28: r = 16'd17867;
                5'd29: r = 16'd17484;
                5'd30: r = 16'd17109;
                default: r = 16'd16743;
            endcase
            return r;
        end
    endfunction

endpackage

@@ rtl/core/row_softmax_unit.sv @@
// row softmax top level: sample store, exponent pass, reciprocal and output pass
//
// usage: pulse start with sample_value while busy is low; each transfer stores one
// signed q8.8 sample and updates the running row maximum. the sample
// that completes a row (row_length samples, 0 acting as 1, above ROW_MAX acting as
// ROW_MAX) raises busy and starts the row pass:
//   exponent pass: one sample read per cycle from the sample ram, 3 pipeline stages
//   reciprocal: computed in a bit-serial divider
//   output pass: one exp read per cycle from the exp ram, 3 pipeline stages
// a row of n samples gives n results, one per cycle with strobe high and
// row_end on the last.
// throughput: one sample per cycle while filling; no sample is taken while busy,
// during the two passes over the rams and the divider.
// results cannot be held off: the receiver takes each one in its strobe cycle.
// cfg_valid/cfg_ready write row_length; cfg_ready is high whenever busy is low.
// reset: row_length 64, empty row, no results pending; ram contents are unknown
// but are always written before they are read.
module row_softmax_unit #(
    parameter int ROW_MAX = rsm_pkg::RowMaxDefault
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [rsm_pkg::SampleWidth-1:0] sample_value,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rsm_pkg::LenWidth-1:0]     cfg_data,
    output logic                             strobe,
    output logic [rsm_pkg::ProbWidth-1:0]    probability,
    output logic                             row_end
);

    localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
    localparam int CW = $clog2(ROW_MAX + 1);

    typedef enum logic [2:0] {
        ST_FILL,
        ST_EXP,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                    state_reg;
    logic [rsm_pkg::LenWidth-1:0] len_reg;
    logic signed [15:0]        max_reg;
    logic [CW-1:0]             fill_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             rd_cnt_reg;
    logic [rsm_pkg::SumWidth-1:0] sum_reg;
    logic [AW-1:0]             rd_addr;

    // exponent pipeline valid/address and output pipeline valid/last
    logic                      ev1_reg, ev2_reg;
    logic [AW-1:0]             ea2_reg, ea3_reg;
    logic [33:0]               p_reg;
    logic [15:0]               e_val;
    logic                      ov1_reg, ov2_reg, ol1_reg, ol2_reg;
    logic [53:0]               prod_reg;
    logic                      div_start_reg;

    logic [15:0]               s_rd, e_rd;
    logic [rsm_pkg::RecipWidth-1:0] recip;
    logic                      div_done;
    logic [CW-1:0]             eff_len;
    logic [CW-1:0]             wr_idx;
    logic                      take;
    logic [16:0]               u_val;
    logic [54:0]               rounded;

    assign take      = start && !busy;
    assign busy      = (state_reg != ST_FILL);
    assign cfg_ready = !busy;

    always_comb
    begin
        if (len_reg == '0)
            eff_len = CW'(1);
        else if ({1'b0, len_reg} > 8'(ROW_MAX))
            eff_len = CW'(ROW_MAX);
        else
            eff_len = CW'(len_reg);
    end

    assign wr_idx  = (fill_reg >= CW'(ROW_MAX)) ? CW'(ROW_MAX - 1) : fill_reg;
    assign rd_addr = rd_cnt_reg[AW-1:0];

    rsm_ram #(.WIDTH(16), .DEPTH(ROW_MAX)) u_sample_ram (
        .clk     (clk),
        .wr_en   (take),
        .wr_addr (wr_idx[AW-1:0]),
        .wr_data (sample_value),
        .rd_addr (rd_addr),
        .rd_data (s_rd)
    );

    // exponent stage 2: u * log2e; stage 3: table and shift
    assign u_val = 17'({max_reg[15], max_reg} - {s_rd[15], s_rd});

    always_comb
    begin
        if (p_reg[33:24] >= 10'd16)
            e_val = '0;
        else
            e_val = rsm_pkg::pow2_frac(p_reg[23:19]) >> p_reg[27:24];
    end

    rsm_ram #(.WIDTH(16), .DEPTH(ROW_MAX)) u_exp_ram (
        .clk     (clk),
        .wr_en   (ev2_reg),
        .wr_addr (ea3_reg),
        .wr_data (e_val),
        .rd_addr (rd_addr),
        .rd_data (e_rd)
    );

    rsm_recip u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (recip)
    );

    assign rounded = {1'b0, prod_reg} + 55'(1 << 20);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            len_reg       <= rsm_pkg::LenWidth'(64);
            max_reg       <= 16'sh8000;
            fill_reg      <= '0;
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            sum_reg       <= '0;
            ev1_reg       <= 1'b0;
            ev2_reg       <= 1'b0;
            ea2_reg       <= '0;
            ea3_reg       <= '0;
            p_reg         <= '0;
            prod_reg      <= '0;
            ov1_reg       <= 1'b0;
            ov2_reg       <= 1'b0;
            ol1_reg       <= 1'b0;
            ol2_reg       <= 1'b0;
            div_start_reg <= 1'b0;
            strobe        <= 1'b0;
            row_end       <= 1'b0;
            probability   <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            strobe        <= ov2_reg;
            row_end       <= ol2_reg;
            if (cfg_valid && cfg_ready)
            begin
                len_reg <= cfg_data;
            end
            // exponent pipeline
            ev1_reg <= (state_reg == ST_EXP) && (rd_cnt_reg < count_reg);
            ev2_reg <= ev1_reg;
            ea2_reg <= rd_addr;
            ea3_reg <= ea2_reg;
            p_reg   <= 34'(u_val) * 34'(rsm_pkg::Log2eQ16);
            if (ev2_reg)
            begin
                sum_reg <= sum_reg + rsm_pkg::SumWidth'(e_val);
            end
            // output pipeline
            ov1_reg  <= (state_reg == ST_OUT) && (rd_cnt_reg < count_reg);
            ol1_reg  <= (state_reg == ST_OUT) && (rd_cnt_reg + 1'b1 == count_reg);
            ov2_reg  <= ov1_reg;
            ol2_reg  <= ol1_reg;
            prod_reg <= 54'(e_rd) * 54'(recip);
            probability <= (rounded[54:21] > 34'd65535) ? 16'hFFFF : rounded[36:21];

            unique case (state_reg)
                ST_FILL:
                begin
                    if (take)
                    begin
                        if (sample_value > max_reg)
                            max_reg <= sample_value;
                        if (wr_idx + 1'b1 >= eff_len)
                        begin
                            count_reg  <= wr_idx + 1'b1;
                            rd_cnt_reg <= '0;
                            sum_reg    <= '0;
                            state_reg  <= ST_EXP;
                        end
                        else
                        begin
                            fill_reg <= wr_idx + 1'b1;
                        end
                    end
                end
                ST_EXP:
                begin
                    if (rd_cnt_reg < count_reg)
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    else if (!ev1_reg && !ev2_reg)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        rd_cnt_reg <= '0;
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (rd_cnt_reg < count_reg)
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    else if (!ov1_reg && !ov2_reg)
                    begin
                        max_reg   <= 16'sh8000;
                        fill_reg  <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_FILL;
                    end
                end
                default:
                begin
                    state_reg <= ST_FILL;
                end
            endcase
        end
    end

    a_no_strobe_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) && !ov2_reg |=> !strobe)
        else $error("result strobe outside output pass");
    a_row_end_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        row_end |-> strobe)
        else $error("row_end without strobe");
    a_no_exp_write_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ev2_reg |-> (state_reg == ST_EXP))
        else $error("exp write outside exponent pass");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(ROW_MAX))
        else $error("fill count beyond row capacity");

endmodule

@@ rtl/core/rsm_ram.sv @@
// generic single-port write, single-port read ram with registered read
module rsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/rsm_recip.sv @@
// restoring divider forming floor(2^37 / sum), one quotient bit per cycle
module rsm_recip (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rsm_pkg::SumWidth-1:0]      divisor,
    output logic                              done,
    output logic [rsm_pkg::RecipWidth-1:0]    quotient
);

    localparam int Steps   = rsm_pkg::RecipWidth;
    localparam int CntBits = $clog2(Steps + 1);

    logic [rsm_pkg::SumWidth-1:0]   div_reg;
    logic [rsm_pkg::SumWidth:0]     rem_reg;
    logic [rsm_pkg::RecipWidth-1:0] quo_reg;
    logic [CntBits-1:0]             cnt_reg;
    logic                           run_reg;
    logic                           done_reg;
    logic [rsm_pkg::SumWidth+1:0]   trial;
    logic                           dividend_bit;

    // dividend is 2^37: only its top bit is set
    assign dividend_bit = (cnt_reg == CntBits'(Steps));
    assign trial = {rem_reg, dividend_bit} - {2'b00, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CntBits'(Steps);
                div_reg <= (divisor == '0) ? rsm_pkg::SumWidth'(1) : divisor;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            else if (run_reg)
            begin
                if (!trial[rsm_pkg::SumWidth+1])
                begin
                    rem_reg <= trial[rsm_pkg::SumWidth:0];
                    quo_reg <= {quo_reg[rsm_pkg::RecipWidth-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[rsm_pkg::SumWidth-1:0], dividend_bit};
                    quo_reg <= {quo_reg[rsm_pkg::RecipWidth-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntBits'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ tb/row_softmax_unit_tb.sv @@
// self-checking testbench for the row softmax unit: directed and random rows with gaps
module row_softmax_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RowCap = rsm_pkg::RowMaxDefault;
    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 60;

    // 2^(-k/32) in q1.15
    localparam logic [15:0] FracTab [32] = '{
        16'd32768, 16'd32066, 16'd31379, 16'd30706, 16'd30048, 16'd29405, 16'd28774, 16'd28158,
        16'd27554, 16'd26964, 16'd26386, 16'd25821, 16'd25268, 16'd24726, 16'd24196, 16'd23678,
        16'd23170, 16'd22674, 16'd22188, 16'd21713, 16'd21247, 16'd20792, 16'd20347, 16'd19911,
        16'd19484, 16'd19066, 16'd18658, 16'd18258, 16'd17867, 16'd17484, 16'd17109, 16'd16743
    };

    typedef struct packed {
        logic [15:0] prob;
        logic        last;
    } prob_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [15:0] sample_value;
    logic cfg_valid;
    logic cfg_ready;
    logic [6:0] cfg_data;
    logic strobe;
    logic [15:0] probability;
    logic row_end;

    row_softmax_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .sample_value(sample_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .strobe      (strobe),
        .probability (probability),
        .row_end     (row_end)
    );

    // model state
    logic signed [15:0] row_samples [RowCap];
    logic signed [15:0] running_max;
    int                 filled;
    logic [6:0]         len_reg;

    prob_t pending_probs[$];
    int    errors;
    int    cycles;
    int    samples_sent;
    int    rows_done;
    int    gap_pct;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout at %0t", $time);
            $display("row_softmax_unit: mismatch");
            $finish;
        end
    end

    function automatic logic [15:0] exp_weight(logic signed [15:0] x, logic signed [15:0] m);
        logic [16:0] u;
        logic [63:0] p;
        logic [63:0] s;
        u = {m[15], m} - {x[15], x};
        p = 64'(u) * 64'd94548;
        s = p >> 24;
        if (s >= 16)
            return 16'd0;
        return FracTab[p[23:19]] >> s;
    endfunction

    // absorb one accepted sample, queue the row's probabilities when it closes
    function automatic void absorb_sample(logic signed [15:0] x);
        int          eff;
        logic [15:0] w [RowCap];
        logic [22:0] total;
        logic [63:0] recip;
        logic [63:0] pr;
        prob_t       p;
        if (filled >= RowCap)
            filled = RowCap - 1;
        row_samples[filled] = x;
        if (x > running_max)
            running_max = x;
        filled++;
        eff = (len_reg < 1) ? 1 : (len_reg > RowCap ? RowCap : int'(len_reg));
        if (filled < eff)
            return;
        total = '0;
        for (int i = 0; i < filled; i++)
        begin
            w[i] = exp_weight(row_samples[i], running_max);
            total = total + 23'(w[i]);
        end
        recip = (64'd1 << 37) / ((total == 0) ? 64'd1 : 64'(total));
        for (int i = 0; i < filled; i++)
        begin
            pr = (64'(w[i]) * recip + (64'd1 << 20)) >> 21;
            p.prob = (pr > 65535) ? 16'hFFFF : pr[15:0];
            p.last = (i + 1 == filled);
            pending_probs.push_back(p);
        end
        running_max = -16'sd32768;
        filled = 0;
        rows_done++;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_probs.size() == 0)
            begin
                $display("%0t: unexpected result prob=%0d row_end=%0b", $time, probability,
                         row_end);
                errors++;
            end
            else
            begin
                prob_t e;
                e = pending_probs.pop_front();
                if (e.prob !== probability)
                begin
                    $display("%0t: probability expected %0d actual %0d", $time, e.prob,
                             probability);
                    errors++;
                end
                if (e.last !== row_end)
                begin
                    $display("%0t: row_end expected %0b actual %0b", $time, e.last, row_end);
                    errors++;
                end
            end
        end
    end

    task automatic send_sample(logic signed [15:0] v);
        if ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            sample_value <= 16'($urandom);
            repeat ($urandom_range(3)) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        sample_value <= v;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        absorb_sample(v);
        samples_sent++;
    endtask

    // wait for every queued probability, then let the block settle
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_probs.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic write_length(logic [6:0] n);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= n;
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        len_reg = n;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        // the extremes row mixes far apart values
        write_length(7'd4);
        send_sample(16'sh7FFF);
        send_sample(-16'sd32768);
        send_sample(16'sd0);
        send_sample(16'sd1);
        // all-equal row, each gets a quarter
        repeat (4) send_sample(-16'sd32768);
        // zero length acts as one: lone sample saturates
        write_length(7'd0);
        send_sample(16'sh5A5A);
        send_sample(-16'sd1);
        write_length(7'd1);
        send_sample(16'sh7FFF);
        // length lowered below the fill level closes the row on the next sample
        write_length(7'd6);
        send_sample(16'sd256);
        send_sample(16'sd128);
        send_sample(-16'sd300);
        write_length(7'd2);
        send_sample(16'sd512);
        // length raised mid-row keeps the stored samples
        send_sample(16'sd10);
        write_length(7'd3);
        send_sample(16'sd20);
        send_sample(16'sd30);
        drain_results();
    endtask

    task automatic test_random(int pct, int quota);
        int n;
        int base;
        int spread;
        int sent;
        gap_pct = pct;
        sent = 0;
        while (sent < quota)
        begin
            case ($urandom_range(9))
                0: n = 0;
                1: n = 127;
                2: n = 64;
                default: n = $urandom_range(1, 16);
            endcase
            write_length(7'(n));
            n = (n < 1) ? 1 : (n > RowCap ? RowCap : n);
            base = $urandom_range(65535) - 32768;
            spread = ($urandom_range(3) == 0) ? 65535 : $urandom_range(1, 2048);
            for (int i = 0; i < n; i++)
            begin
                int v;
                if ($urandom_range(7) == 0)
                    v = $urandom_range(65535) - 32768;
                else
                    v = base + $urandom_range(spread) - spread / 2;
                v = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
                send_sample(16'(v));
            end
            sent += n;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        sample_value = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        samples_sent = 0;
        rows_done = 0;
        gap_pct = 0;
        len_reg = 7'd64;
        running_max = -16'sd32768;
        filled = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(29, 90);
        test_random(58, 90);
        test_random(0, 100);
        drain_results();

        $display("covered %0d samples in %0d rows, lengths 0 to 127 incl. mid-row changes",
                 samples_sent, rows_done);
        $display("sender gap rates 29, 58 and 0 percent, full-scale and clustered logits");
        if (errors == 0 && pending_probs.size() == 0)
            $display("row_softmax_unit: match");
        else
            $display("row_softmax_unit: mismatch");
        $finish;
    end
endmodule
